FILE: rtl/core/osw_pkg.sv
package osw_pkg;

    // default geometry of the window ring
    localparam int RING_DEPTH_DEF  = 4096;
    localparam int OFFSET_BITS_DEF = 48;

    // width of one stored stream byte
    localparam int BYTE_W = 8;

endpackage

FILE: rtl/core/osw_ring.sv
module osw_ring #(
    parameter int DEPTH = osw_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [osw_pkg::BYTE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [osw_pkg::BYTE_W-1:0] rd_data
);

    logic [osw_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [osw_pkg::BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/offset_addressed_stream_window_core.sv
// Byte window over a stream, addressed by absolute stream offsets, held in a
// ring of RING_DEPTH bytes (power of two). Each item is one command: push a
// byte at the end offset, read the byte at an offset (zero and in_window low
// outside [start, end)), or advance the start to an offset (clamped to the
// end, ignored when behind the start). Every item gives exactly one result
// item. An item passes through capture, one ring access (the ring memory
// has a registered read port) together with the offset-minus-start
// subtraction, then the window compare and update, which writes the result
// register. A new item is taken only once the previous one has been
// resolved. One item is in flight at a time; a finished result waits in the
// output register while the next item is taken, and that next item holds in
// its resolve step until the waiting result is taken. A push into a full
// ring is dropped and reported with accepted low. OFFSET_BITS must be at least
// log2(RING_DEPTH)+1.
module offset_addressed_stream_window_core #(
    parameter int RING_DEPTH  = osw_pkg::RING_DEPTH_DEF,
    parameter int OFFSET_BITS = osw_pkg::OFFSET_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // command items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [osw_pkg::BYTE_W-1:0] s_push_byte,
    input  logic [OFFSET_BITS-1:0]     s_stream_offset,
    input  logic                       s_span_last,
    // result items
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [osw_pkg::BYTE_W-1:0] m_read_byte,
    output logic                       m_in_window,
    output logic                       m_accepted,
    output logic [$clog2(RING_DEPTH):0] m_fill_level,
    output logic                       m_result_last
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int FILL_W = AW + 1;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_RESOLVE
    } state_t;

    state_t                     state_reg;
    cmd_t                       cmd_reg;
    logic [osw_pkg::BYTE_W-1:0] byte_reg;
    logic [OFFSET_BITS-1:0]     ofs_reg;
    logic                       last_reg;
    logic [OFFSET_BITS-1:0]     gap_reg;
    logic [OFFSET_BITS-1:0]     gap_next;
    logic                       acc_reg;

    logic [OFFSET_BITS-1:0]     start_reg;
    logic [OFFSET_BITS-1:0]     end_reg;
    logic [FILL_W-1:0]          fill_reg;

    logic                       m_valid_reg;
    logic [osw_pkg::BYTE_W-1:0] m_read_byte_reg;
    logic                       m_in_window_reg;
    logic                       m_accepted_reg;
    logic [FILL_W-1:0]          m_fill_level_reg;
    logic                       m_result_last_reg;

    logic                       ring_full;
    logic                       ring_wr_en;
    logic                       ring_rd_en;
    logic [osw_pkg::BYTE_W-1:0] ring_rd_data;
    logic [OFFSET_BITS-1:0]     fill_ext;
    logic                       in_win;
    logic                       adv_take;
    logic                       adv_clamp;
    logic                       out_free;

    // ring memory
    osw_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (end_reg[AW-1:0]),
        .wr_data (byte_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (ofs_reg[AW-1:0]),
        .rd_data (ring_rd_data)
    );

    // ring access and window arithmetic
    always_comb begin
        ring_full  = (fill_reg == FILL_W'(RING_DEPTH));
        ring_wr_en = (state_reg == ST_ACCESS) && (cmd_reg == CMD_PUSH) && !ring_full;
        ring_rd_en = (state_reg == ST_ACCESS) && (cmd_reg == CMD_READ);
        gap_next   = OFFSET_BITS'(ofs_reg - start_reg);
        fill_ext   = OFFSET_BITS'(fill_reg);
        in_win     = (cmd_reg == CMD_READ) && (gap_reg < fill_ext);
        adv_take   = (cmd_reg == CMD_ADVANCE) && (gap_reg <= fill_ext);
        adv_clamp  = (cmd_reg == CMD_ADVANCE) && !(gap_reg <= fill_ext)
                     && !gap_reg[OFFSET_BITS-1];
        out_free   = !m_valid_reg || m_ready;
    end

    // sequencer, window registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= '0;
            end_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_RESOLVE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= cmd_t'(s_command);
                        byte_reg  <= s_push_byte;
                        ofs_reg   <= s_stream_offset;
                        last_reg  <= s_span_last;
                        state_reg <= ST_ACCESS;
                    end
                end
                ST_ACCESS: begin
                    // push writes the ring here, reads are issued here
                    gap_reg <= gap_next;
                    acc_reg <= !((cmd_reg == CMD_PUSH) && ring_full);
                    if (ring_wr_en) begin
                        end_reg  <= OFFSET_BITS'(end_reg + 1'b1);
                        fill_reg <= FILL_W'(fill_reg + 1'b1);
                    end
                    state_reg <= ST_RESOLVE;
                end
                ST_RESOLVE: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_read_byte_reg   <= in_win ? ring_rd_data : '0;
                        m_in_window_reg   <= in_win;
                        m_accepted_reg    <= acc_reg;
                        m_result_last_reg <= last_reg;
                        if (adv_take) begin
                            start_reg        <= ofs_reg;
                            fill_reg         <= FILL_W'(fill_reg - gap_reg[FILL_W-1:0]);
                            m_fill_level_reg <= FILL_W'(fill_reg - gap_reg[FILL_W-1:0]);
                        end else if (adv_clamp) begin
                            start_reg        <= end_reg;
                            fill_reg         <= '0;
                            m_fill_level_reg <= '0;
                        end else begin
                            m_fill_level_reg <= fill_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_read_byte   = m_read_byte_reg;
    assign m_in_window   = m_in_window_reg;
    assign m_accepted    = m_accepted_reg;
    assign m_fill_level  = m_fill_level_reg;
    assign m_result_last = m_result_last_reg;

`ifndef SYNTHESIS
    // fill never exceeds the ring
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill level beyond ring depth");

    // fill always matches the distance from start to end
    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        OFFSET_BITS'(end_reg - start_reg) == fill_ext)
        else $error("fill level out of step with window offsets");

    // one item at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item taken while another is in flight");

    // padding zero outside the window
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_window) |-> (m_read_byte == '0))
        else $error("non-zero byte outside window");

    // a rejected push leaves the end offset alone
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCESS && cmd_reg == CMD_PUSH && ring_full) |=>
        $stable(end_reg))
        else $error("push into full ring moved the end");
`endif

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = osw_pkg::RING_DEPTH_DEF;
    localparam int OBITS        = osw_pkg::OFFSET_BITS_DEF;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int FILL_W       = IDX_W + 1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int FULL_AT      = 400;

    typedef logic [OBITS-1:0] ofs_t;

    localparam ofs_t OFS_HALF = ofs_t'(1) << (OBITS - 1);
    localparam ofs_t OFS_ALL  = '1;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_e;

    typedef struct packed {
        logic [osw_pkg::BYTE_W-1:0] read_byte;
        logic                       in_window;
        logic                       accepted;
        logic [FILL_W-1:0]          fill_level;
        logic                       result_last;
    } answer_t;

    typedef struct {
        cmd_e                       cmd;
        logic [osw_pkg::BYTE_W-1:0] data;
        ofs_t                       ofs;
        logic                       last;
        bit                         typed;
        answer_t                    answer;
    } stim_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_command;
    logic [osw_pkg::BYTE_W-1:0] s_push_byte;
    ofs_t                       s_stream_offset;
    logic                       s_span_last;
    logic                       m_valid;
    logic                       m_ready;
    logic [osw_pkg::BYTE_W-1:0] m_read_byte;
    logic                       m_in_window;
    logic                       m_accepted;
    logic [FILL_W-1:0]          m_fill_level;
    logic                       m_result_last;

    // shadow of the window state
    logic [osw_pkg::BYTE_W-1:0] ring_shadow [DEPTH];
    ofs_t                       start_ofs;
    ofs_t                       end_ofs;

    answer_t   answers_due [$];
    stim_row_t stim_table [$];
    int        errors;
    int        items_sent;
    int        burst_left;
    int        fill_items;
    int        rx_mode;
    int        rx_mode_left;
    int        rx_hold;
    answer_t   got;
    answer_t   want;

    offset_addressed_stream_window_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_push_byte     (s_push_byte),
        .s_stream_offset (s_stream_offset),
        .s_span_last     (s_span_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_byte     (m_read_byte),
        .m_in_window     (m_in_window),
        .m_accepted      (m_accepted),
        .m_fill_level    (m_fill_level),
        .m_result_last   (m_result_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #(10_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // window behaviour for one command, updating the shadow state
    function automatic answer_t predict_window_answer(cmd_e cmd,
                                                      logic [osw_pkg::BYTE_W-1:0] data,
                                                      ofs_t ofs, logic last);
        answer_t r;
        ofs_t    fill;
        ofs_t    gap;
        fill = end_ofs - start_ofs;
        gap = ofs - start_ofs;
        r = '0;
        r.accepted = 1'b1;
        r.result_last = last;
        case (cmd)
            CMD_PUSH: begin
                if (fill >= DEPTH) begin
                    r.accepted = 1'b0;
                end else begin
                    ring_shadow[end_ofs[IDX_W-1:0]] = data;
                    end_ofs = end_ofs + 1'b1;
                end
            end
            CMD_READ: begin
                if (gap < fill) begin
                    r.in_window = 1'b1;
                    r.read_byte = ring_shadow[ofs[IDX_W-1:0]];
                end
            end
            CMD_ADVANCE: begin
                // forward within reach, clamped past the end, ignored behind the start
                if (gap <= fill) begin
                    start_ofs = ofs;
                end else if (!gap[OBITS-1]) begin
                    start_ofs = end_ofs;
                end
            end
            default: begin
            end
        endcase
        fill = end_ofs - start_ofs;
        r.fill_level = fill[FILL_W-1:0];
        return r;
    endfunction

    function automatic void report_failure(string what);
        errors++;
        if (errors <= 10) $display("%s", what);
    endfunction

    function automatic void add_row(cmd_e cmd, logic [7:0] data, ofs_t ofs, logic last,
                                    bit typed, logic [7:0] rb, logic iw, int fill);
        stim_row_t row;
        row.cmd = cmd;
        row.data = data;
        row.ofs = ofs;
        row.last = last;
        row.typed = typed;
        row.answer = '{rb, iw, 1'b1, FILL_W'(fill), last};
        stim_table = {stim_table, row};
    endfunction

    function automatic ofs_t wide_random();
        return ofs_t'({$urandom, $urandom});
    endfunction

    // offsets around and inside the current window
    function automatic ofs_t pick_offset();
        ofs_t fill;
        fill = end_ofs - start_ofs;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (fill == 0) return start_ofs;
                return start_ofs + $urandom_range(0, int'(fill) - 1);
            end
            5: return end_ofs;
            6: return start_ofs - 1'b1;
            7: return end_ofs + $urandom_range(1, 8);
            8: return start_ofs + OFS_HALF + $urandom_range(0, 2) - 1'b1;
            default: return wide_random();
        endcase
    endfunction

    // send one item, wait for it to be taken, then maybe pause the sender
    task automatic issue(cmd_e cmd, logic [osw_pkg::BYTE_W-1:0] data, ofs_t ofs,
                         logic last, bit typed = 1'b0, answer_t typed_answer = '0);
        answer_t r;
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_push_byte     <= data;
        s_stream_offset <= ofs;
        s_span_last     <= last;
        do @(posedge aclk); while (!s_ready);
        r = predict_window_answer(cmd, data, ofs, last);
        answers_due = {answers_due, (typed ? typed_answer : r)};
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
        end
    endtask

    task automatic push_span(int len);
        for (int i = 0; i < len; i++) begin
            issue(CMD_PUSH, 8'($urandom), wide_random(), i == len - 1);
        end
    endtask

    task automatic read_span(ofs_t base, int len);
        for (int i = 0; i < len; i++) begin
            issue(CMD_READ, 8'($urandom), base + i, i == len - 1);
        end
    endtask

    task automatic advance_step();
        ofs_t fill;
        ofs_t target;
        fill = end_ofs - start_ofs;
        if ($urandom_range(0, 9) < 7) target = start_ofs + $urandom_range(0, int'(fill));
        else target = pick_offset();
        issue(CMD_ADVANCE, 8'($urandom), target, 1'($urandom));
    endtask

    // fill the ring to the brim, push into it while full, read it, then drain part
    task automatic fill_ring();
        ofs_t fill;
        fill = end_ofs - start_ofs;
        while (fill < DEPTH) begin
            if ($urandom_range(0, 15) == 0) read_span(pick_offset(), 1);
            else issue(CMD_PUSH, 8'($urandom), wide_random(), $urandom_range(0, 7) == 0);
            fill = end_ofs - start_ofs;
        end
        push_span(4);
        read_span(start_ofs, 2);
        read_span(end_ofs - 1'b1, 2);
        for (int i = 0; i < 8; i++) read_span(pick_offset(), 1);
        issue(CMD_ADVANCE, 8'($urandom), start_ofs + $urandom_range(DEPTH / 2, DEPTH - 1),
              1'b0);
    endtask

    // receiver: checks each result item and stalls on its own pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = '{m_read_byte, m_in_window, m_accepted, m_fill_level, m_result_last};
            if (answers_due.size() == 0) begin
                report_failure($sformatf("unexpected result: byte %h win %b acc %b fill %0d last %b",
                               got.read_byte, got.in_window, got.accepted, got.fill_level,
                               got.result_last));
            end else begin
                want = answers_due[0];
                answers_due.delete(0);
                if (got !== want) begin
                    report_failure($sformatf({"mismatch: expected byte %h win %b acc %b ",
                                   "fill %0d last %b, got byte %h win %b acc %b fill %0d last %b"},
                                   want.read_byte, want.in_window, want.accepted,
                                   want.fill_level, want.result_last, got.read_byte,
                                   got.in_window, got.accepted, got.fill_level,
                                   got.result_last));
                end
            end
        end
        // stall pattern changes now and then
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 6);
                end
            end
        endcase
    end

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_command       <= CMD_NOP;
        s_push_byte     <= '0;
        s_stream_offset <= '0;
        s_span_last     <= 1'b0;
        m_ready         <= 1'b0;
        start_ofs    = '0;
        end_ofs      = '0;
        errors       = 0;
        items_sent   = 0;
        burst_left   = 0;
        fill_items   = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        rx_hold      = 0;

        // directed items: empty window, extremes, clamp and ignore on advance
        add_row(CMD_READ,    8'h00, '0,            1'b1, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_ADVANCE, 8'hFF, '0,            1'b0, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_ADVANCE, 8'h00, ofs_t'(5),     1'b1, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_NOP,     8'hFF, OFS_ALL,       1'b1, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_PUSH,    8'h00, OFS_ALL,       1'b0, 1'b1, 8'h00, 1'b0, 1);
        add_row(CMD_PUSH,    8'hFF, '0,            1'b0, 1'b1, 8'h00, 1'b0, 2);
        add_row(CMD_PUSH,    8'hA5, '0,            1'b1, 1'b1, 8'h00, 1'b0, 3);
        add_row(CMD_READ,    8'h00, ofs_t'(0),     1'b0, 1'b1, 8'h00, 1'b1, 3);
        add_row(CMD_READ,    8'h00, ofs_t'(1),     1'b0, 1'b1, 8'hFF, 1'b1, 3);
        add_row(CMD_READ,    8'h00, ofs_t'(2),     1'b1, 1'b1, 8'hA5, 1'b1, 3);
        add_row(CMD_READ,    8'h00, ofs_t'(3),     1'b0, 1'b1, 8'h00, 1'b0, 3);
        add_row(CMD_READ,    8'hFF, OFS_ALL,       1'b1, 1'b1, 8'h00, 1'b0, 3);
        add_row(CMD_ADVANCE, 8'h00, ofs_t'(1),     1'b0, 1'b1, 8'h00, 1'b0, 2);
        add_row(CMD_READ,    8'h00, ofs_t'(0),     1'b0, 1'b1, 8'h00, 1'b0, 2);
        add_row(CMD_ADVANCE, 8'h00, ofs_t'(0),     1'b0, 1'b1, 8'h00, 1'b0, 2);
        add_row(CMD_ADVANCE, 8'h00, OFS_HALF + 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 2);
        add_row(CMD_ADVANCE, 8'h00, OFS_HALF,      1'b1, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_READ,    8'h00, ofs_t'(2),     1'b0, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_PUSH,    8'h5A, ofs_t'(0),     1'b0, 1'b1, 8'h00, 1'b0, 1);
        add_row(CMD_READ,    8'h00, ofs_t'(3),     1'b1, 1'b1, 8'h5A, 1'b1, 1);
        add_row(CMD_ADVANCE, 8'h00, ofs_t'(4),     1'b0, 1'b1, 8'h00, 1'b0, 0);
        add_row(CMD_PUSH,    8'h3C, OFS_ALL,       1'b1, 1'b0, 8'h00, 1'b0, 0);
        add_row(CMD_READ,    8'h00, ofs_t'(4),     1'b0, 1'b0, 8'h00, 1'b0, 0);
        add_row(CMD_PUSH,    8'hC3, ofs_t'(0),     1'b0, 1'b0, 8'h00, 1'b0, 0);
        add_row(CMD_READ,    8'h00, ofs_t'(5),     1'b1, 1'b0, 8'h00, 1'b0, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            issue(stim_table[i].cmd, stim_table[i].data, stim_table[i].ofs,
                  stim_table[i].last, stim_table[i].typed, stim_table[i].answer);
        end

        // random spans of commands, with one trip to a full ring on the way
        while (items_sent < stim_table.size() + RANDOM_ITEMS + fill_items) begin
            if (fill_items == 0 && items_sent >= FULL_AT) begin
                fill_items = items_sent;
                fill_ring();
                fill_items = items_sent - fill_items;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_span($urandom_range(1, 12));
                4, 5, 6:    read_span(pick_offset(), $urandom_range(1, 8));
                7, 8:       advance_step();
                default: begin
                    issue(cmd_e'($urandom_range(0, 3)), 8'($urandom), wide_random(),
                          1'($urandom));
                end
            endcase
        end
        s_valid <= 1'b0;

        // drain outstanding results, then allow for a late stray item
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
